>>> hdl/ps2md_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
package ps2md_pkg;

  // Default widths of the position accumulators and the event counters.
  localparam int unsigned AccumWidthDef = 32;
  localparam int unsigned CountWidthDef = 32;

  // Fixed widths of the link byte and of the reported fields.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OutW    = 32;
  localparam int unsigned ButtonW = 3;
  localparam int unsigned PosW    = 2;

  // Bit positions inside the first packet byte.
  localparam int unsigned MarkerBit = 3;
  localparam int unsigned SignXBit  = 4;
  localparam int unsigned SignYBit  = 5;

  // Nibble holding the wheel delta in the fourth byte.
  localparam int unsigned WheelW = 4;

  // Byte positions within a packet.
  localparam logic [PosW-1:0] PosFirst  = 2'd0;
  localparam logic [PosW-1:0] PosSecond = 2'd1;
  localparam logic [PosW-1:0] PosThird  = 2'd2;
  localparam logic [PosW-1:0] PosFourth = 2'd3;

  // One result item as it leaves the decoder.
  typedef struct packed {
    logic signed [OutW-1:0] pos_x;
    logic signed [OutW-1:0] pos_y;
    logic signed [OutW-1:0] wheel_total;
    logic [ButtonW-1:0]     button_bits;
    logic [OutW-1:0]        packet_count;
    logic [OutW-1:0]        resync_count;
    logic                   packet_done;
    logic                   byte_dropped;
  } ps2md_res_t;

endpackage

>>> hdl/ps2md_byte_if.sv
// Channel that carries received mouse bytes into the decoder.
interface ps2md_byte_if
  import ps2md_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hdl/ps2md_result_if.sv
// Channel that carries decoded result items out of the decoder.
interface ps2md_result_if
  import ps2md_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] pos_x;
  logic signed [OutW-1:0] pos_y;
  logic signed [OutW-1:0] wheel_total;
  logic [ButtonW-1:0]     button_bits;
  logic [OutW-1:0]        packet_count;
  logic [OutW-1:0]        resync_count;
  logic                   packet_done;
  logic                   byte_dropped;

  modport source (
    output valid, output pos_x, output pos_y, output wheel_total, output button_bits,
    output packet_count, output resync_count, output packet_done, output byte_dropped,
    input ready
  );
  modport sink (
    input valid, input pos_x, input pos_y, input wheel_total, input button_bits,
    input packet_count, input resync_count, input packet_done, input byte_dropped,
    output ready
  );
endinterface

>>> hdl/ps2md_in_reg.sv
// Input register stage that captures one received byte per cycle while it is empty or its byte moves on.
module ps2md_in_reg
  import ps2md_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  ps2md_byte_if.sink       rx_i,
  input  logic             down_ready_i,
  output logic             valid_o,
  output logic [ByteW-1:0] rx_byte_o
);

  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  logic             load;

  // The stage refills whenever it is empty or its item moves on.
  assign rx_i.ready = !valid_q || down_ready_i;
  assign load       = rx_i.valid && rx_i.ready;

  // Valid flag of the held item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      valid_q <= rx_i.valid;
    end
  end

  // Held byte.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o   = valid_q;
  assign rx_byte_o = byte_q;

endmodule

>>> hdl/ps2md_core.sv
// Packet assembly, delta decode and accumulator state of the decoder.
module ps2md_core
  import ps2md_pkg::*;
#(
  parameter int unsigned ACCUM_WIDTH = AccumWidthDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wheel_mode_we_i,
  input  logic             wheel_mode_i,
  input  logic             take_i,
  input  logic [ByteW-1:0] rx_byte_i,
  output ps2md_res_t       res_o
);

  logic                   wheel_mode_q;
  logic [PosW-1:0]        pos_q, pos_d;
  logic [ByteW-1:0]       held_q [3];
  logic [ACCUM_WIDTH-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [ButtonW-1:0]     btn_q, btn_d;
  logic [COUNT_WIDTH-1:0] pkt_q, pkt_d, rsy_q, rsy_d;

  logic                   drop, hold, done, add_wheel;
  logic [ByteW-1:0]       flags, ybyte;
  logic [ACCUM_WIDTH-1:0] dx, dy, dz;

  // Classify the byte: lost sync, part of a packet, or the last byte.
  always_comb begin
    drop      = (pos_q == PosFirst) && !rx_byte_i[MarkerBit];
    hold      = !drop && (wheel_mode_q ? (pos_q != PosFourth)
                                        : (pos_q == PosFirst || pos_q == PosSecond));
    done      = !drop && !hold;
    add_wheel = done && wheel_mode_q && (pos_q == PosFourth);
  end

  // Sign-extend the deltas; the sign bits of X and Y live in the first byte.
  always_comb begin
    flags = held_q[0];
    ybyte = (pos_q == PosThird) ? rx_byte_i : held_q[2];
    dx    = {{(ACCUM_WIDTH-ByteW){flags[SignXBit]}}, held_q[1]};
    dy    = {{(ACCUM_WIDTH-ByteW){flags[SignYBit]}}, ybyte};
    dz    = {{(ACCUM_WIDTH-WheelW){rx_byte_i[WheelW-1]}}, rx_byte_i[WheelW-1:0]};
  end

  // Next state for this byte.
  always_comb begin
    pos_d = pos_q;
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    btn_d = btn_q;
    pkt_d = pkt_q;
    rsy_d = rsy_q;
    if (drop) begin
      rsy_d = rsy_q + COUNT_WIDTH'(1);
    end else if (hold) begin
      pos_d = pos_q + PosW'(1);
    end else begin
      pos_d = PosFirst;
      x_d   = x_q + dx;
      y_d   = y_q + dy;
      btn_d = flags[ButtonW-1:0];
      pkt_d = pkt_q + COUNT_WIDTH'(1);
      if (add_wheel) begin
        z_d = z_q + dz;
      end
    end
  end

  // Mode register, to be written only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_mode_q <= 1'b0;
    end else if (wheel_mode_we_i) begin
      wheel_mode_q <= wheel_mode_i;
    end
  end

  // Totals, buttons, counters and packet position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosFirst;
      x_q   <= '0;
      y_q   <= '0;
      z_q   <= '0;
      btn_q <= '0;
      pkt_q <= '0;
      rsy_q <= '0;
    end else if (take_i) begin
      pos_q <= pos_d;
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      btn_q <= btn_d;
      pkt_q <= pkt_d;
      rsy_q <= rsy_d;
    end
  end

  // Bytes of the packet in progress; each is written before it is read.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (take_i && hold && (pos_q == PosW'(i))) begin
        held_q[i] <= rx_byte_i;
      end
    end
  end

  // Reported totals and counters are the low bits of their next-state values, zero-filled if narrower.
  generate
    if (ACCUM_WIDTH >= OutW) begin : g_acc_trunc
      assign res_o.pos_x       = x_d[OutW-1:0];
      assign res_o.pos_y       = y_d[OutW-1:0];
      assign res_o.wheel_total = z_d[OutW-1:0];
    end else begin : g_acc_ext
      assign res_o.pos_x       = {{(OutW-ACCUM_WIDTH){1'b0}}, x_d};
      assign res_o.pos_y       = {{(OutW-ACCUM_WIDTH){1'b0}}, y_d};
      assign res_o.wheel_total = {{(OutW-ACCUM_WIDTH){1'b0}}, z_d};
    end
    if (COUNT_WIDTH >= OutW) begin : g_cnt_trunc
      assign res_o.packet_count = pkt_d[OutW-1:0];
      assign res_o.resync_count = rsy_d[OutW-1:0];
    end else begin : g_cnt_ext
      assign res_o.packet_count = {{(OutW-COUNT_WIDTH){1'b0}}, pkt_d};
      assign res_o.resync_count = {{(OutW-COUNT_WIDTH){1'b0}}, rsy_d};
    end
  endgenerate

  assign res_o.button_bits  = btn_d;
  assign res_o.packet_done  = done;
  assign res_o.byte_dropped = drop;

endmodule

>>> hdl/ps2md_out_reg.sv
// Result register stage that holds one item until the sink takes it.
module ps2md_out_reg
  import ps2md_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ps2md_res_t     res_i,
  output logic           ready_o,
  ps2md_result_if.source res_o
);

  logic       valid_q;
  ps2md_res_t res_q;

  // A new item may enter when the stage is empty or is being emptied.
  assign ready_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  // Drive the result channel from the held item.
  assign res_o.valid        = valid_q;
  assign res_o.pos_x        = res_q.pos_x;
  assign res_o.pos_y        = res_q.pos_y;
  assign res_o.wheel_total  = res_q.wheel_total;
  assign res_o.button_bits  = res_q.button_bits;
  assign res_o.packet_count = res_q.packet_count;
  assign res_o.resync_count = res_q.resync_count;
  assign res_o.packet_done  = res_q.packet_done;
  assign res_o.byte_dropped = res_q.byte_dropped;

endmodule

>>> hdl/ps2_mouse_packet_decoder.sv
// PS/2 mouse packet decoder, one byte per cycle, 3-byte or 4-byte wheel packets.
// Each received byte is one input item and yields exactly one result item that
// carries the running X, Y and wheel totals, the buttons of the last packet, the
// packet and resync counters, and flags telling whether this byte finished a
// packet or was dropped because a first byte lacked its always-one bit. The
// decoder takes a new byte every cycle unless the input is stalled; a byte is registered
// on entry, then decoded and folded into the totals when the output register has
// room, and its result is loaded into that output register at the same edge,
// from which it is offered until the sink takes it.
// Throughput is set by the single decode stage between these two registers; the
// input only stalls when the output register holds an item that is not taken.
// wheel_mode should only be written while no byte is in flight.
module ps2_mouse_packet_decoder
  import ps2md_pkg::*;
#(
  parameter int unsigned ACCUM_WIDTH = AccumWidthDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wheel_mode_we_i,
  input  logic           wheel_mode_i,
  ps2md_byte_if.sink     rx_i,
  ps2md_result_if.source res_o
);

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             out_ready;
  logic             take;
  ps2md_res_t       core_res;

  // The decode stage fires when it holds a byte and the result register has room.
  assign take = s1_valid && out_ready;

  ps2md_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .down_ready_i (out_ready),
    .valid_o      (s1_valid),
    .rx_byte_o    (s1_byte)
  );

  ps2md_core #(
    .ACCUM_WIDTH (ACCUM_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wheel_mode_we_i (wheel_mode_we_i),
    .wheel_mode_i    (wheel_mode_i),
    .take_i          (take),
    .rx_byte_i       (s1_byte),
    .res_o           (core_res)
  );

  ps2md_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take),
    .res_i   (core_res),
    .ready_o (out_ready),
    .res_o   (res_o)
  );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the PS/2 mouse packet decoder: directed table, then random packets.
module tb;
  import ps2md_pkg::*;

  localparam int unsigned ClkHalf      = 10;
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned SegItems     = 120;
  localparam int unsigned SegsPerPhase = 4;
  localparam int unsigned HoldAfter    = 300;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned CycleLimit   = 200000;

  typedef enum logic {RowByte, RowMode} row_kind_e;

  // One line of the directed stimulus, with an optional hand-written result.
  typedef struct packed {
    row_kind_e        kind;
    logic [ByteW-1:0] value;
    logic             typed;
    ps2md_res_t       res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic wheel_mode_we_i = 1'b0;
  logic wheel_mode_i = 1'b0;

  ps2md_byte_if   rx_ch ();
  ps2md_result_if res_ch ();

  ps2_mouse_packet_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wheel_mode_we_i (wheel_mode_we_i),
    .wheel_mode_i    (wheel_mode_i),
    .rx_i            (rx_ch),
    .res_o           (res_ch)
  );

  // Decoder state as the predictor sees it.
  logic                   wheel_q = 1'b0;
  logic [PosW-1:0]        pos_q = PosFirst;
  logic [ByteW-1:0]       held_q [3];
  logic signed [OutW-1:0] x_q = '0;
  logic signed [OutW-1:0] y_q = '0;
  logic signed [OutW-1:0] wheel_sum_q = '0;
  logic [ButtonW-1:0]     buttons_q = '0;
  logic [OutW-1:0]        packets_q = '0;
  logic [OutW-1:0]        resyncs_q = '0;

  ps2md_res_t  pending_results [$];
  stim_row_t   dir_rows [$];
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned mode_writes = 0;
  int unsigned results_seen = 0;
  int unsigned packets_checked = 0;
  int unsigned drops_checked = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned cycle_cnt = 0;

  // Free-running clock.
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Works out the result of one byte and advances the predicted state.
  function automatic ps2md_res_t decode_byte(input logic [ByteW-1:0] b);
    ps2md_res_t r;
    logic [ByteW-1:0] flags;
    logic [ByteW-1:0] ybyte;
    int plen;
    r = '0;
    plen = wheel_q ? 4 : 3;
    if (pos_q == PosFirst && !b[MarkerBit]) begin
      // First byte without its always-one bit is thrown away.
      resyncs_q = resyncs_q + 1;
      r.byte_dropped = 1'b1;
    end else if (int'(pos_q) + 1 < plen) begin
      if (pos_q != PosFourth) held_q[pos_q] = b;
      pos_q = pos_q + 1'b1;
    end else begin
      // Packet complete; a packet cut short by a mode change uses the held bytes.
      flags = (pos_q == PosFirst) ? b : held_q[0];
      ybyte = (pos_q == PosThird) ? b : held_q[2];
      x_q = x_q + {{(OutW-ByteW){flags[SignXBit]}}, held_q[1]};
      y_q = y_q + {{(OutW-ByteW){flags[SignYBit]}}, ybyte};
      buttons_q = flags[ButtonW-1:0];
      if (wheel_q && pos_q == PosFourth)
        wheel_sum_q = wheel_sum_q + {{(OutW-WheelW){b[WheelW-1]}}, b[WheelW-1:0]};
      packets_q = packets_q + 1;
      pos_q = PosFirst;
      r.packet_done = 1'b1;
    end
    r.pos_x = x_q;
    r.pos_y = y_q;
    r.wheel_total = wheel_sum_q;
    r.button_bits = buttons_q;
    r.packet_count = packets_q;
    r.resync_count = resyncs_q;
    return r;
  endfunction

  function automatic stim_row_t stim_row(input row_kind_e kind, input logic [ByteW-1:0] value,
                                         input logic typed, input int px, input int py,
                                         input int btn, input int pkts, input int rsy,
                                         input logic done, input logic drop);
    stim_row_t s;
    s = '0;
    s.kind = kind;
    s.value = value;
    s.typed = typed;
    s.res.pos_x = px;
    s.res.pos_y = py;
    s.res.button_bits = btn[ButtonW-1:0];
    s.res.packet_count = pkts;
    s.res.resync_count = rsy;
    s.res.packet_done = done;
    s.res.byte_dropped = drop;
    return s;
  endfunction

  // Offers one byte, waits for it to be taken and records what must come back.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic typed,
                           input ps2md_res_t typed_res);
    ps2md_res_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    want = decode_byte(b);
    pending_results.push_back(typed ? typed_res : want);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // The mode register is only written once the decoder has nothing in flight.
  task automatic write_mode(input logic m);
    wait_drained();
    wheel_mode_we_i <= 1'b1;
    wheel_mode_i <= m;
    @(posedge clk_i);
    wheel_mode_we_i <= 1'b0;
    wheel_q = m;
    mode_writes++;
  endtask

  // Result side: random stalls plus one long hold-off that backs up the input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HoldAfter) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each accepted result item with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    ps2md_res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got pos_x %0d packet_count %0d",
                 $time, res_ch.pos_x, res_ch.packet_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.packet_done) packets_checked++;
        if (want.byte_dropped) drops_checked++;
        if (res_ch.pos_x !== want.pos_x) begin
          $display("%0t: pos_x expected %0d got %0d", $time, want.pos_x, res_ch.pos_x);
          error_count++;
        end
        if (res_ch.pos_y !== want.pos_y) begin
          $display("%0t: pos_y expected %0d got %0d", $time, want.pos_y, res_ch.pos_y);
          error_count++;
        end
        if (res_ch.wheel_total !== want.wheel_total) begin
          $display("%0t: wheel_total expected %0d got %0d", $time, want.wheel_total,
                   res_ch.wheel_total);
          error_count++;
        end
        if (res_ch.button_bits !== want.button_bits) begin
          $display("%0t: button_bits expected %0d got %0d", $time, want.button_bits,
                   res_ch.button_bits);
          error_count++;
        end
        if (res_ch.packet_count !== want.packet_count) begin
          $display("%0t: packet_count expected %0d got %0d", $time, want.packet_count,
                   res_ch.packet_count);
          error_count++;
        end
        if (res_ch.resync_count !== want.resync_count) begin
          $display("%0t: resync_count expected %0d got %0d", $time, want.resync_count,
                   res_ch.resync_count);
          error_count++;
        end
        if (res_ch.packet_done !== want.packet_done) begin
          $display("%0t: packet_done expected %0d got %0d", $time, want.packet_done,
                   res_ch.packet_done);
          error_count++;
        end
        if (res_ch.byte_dropped !== want.byte_dropped) begin
          $display("%0t: byte_dropped expected %0d got %0d", $time, want.byte_dropped,
                   res_ch.byte_dropped);
          error_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then three handshake phases of random packets.
  initial begin
    int unsigned phase;
    int unsigned seg;
    int unsigned sent_at_start;
    int unsigned pick;
    int unsigned plen;
    int unsigned extra;
    logic [ByteW-1:0] b;

    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;

    // Bytes of standard packets: lost sync, an all-zero packet, all-ones extremes.
    dir_rows.push_back(stim_row(RowByte, 8'h00, 1'b1, 0, 0, 0, 0, 1, 1'b0, 1'b1));
    dir_rows.push_back(stim_row(RowByte, 8'h08, 1'b1, 0, 0, 0, 0, 1, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h00, 1'b1, 0, 0, 0, 0, 1, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h00, 1'b1, 0, 0, 0, 1, 1, 1'b1, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'hFF, 1'b1, 0, 0, 0, 1, 1, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'hFF, 1'b1, 0, 0, 0, 1, 1, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'hFF, 1'b1, -1, -1, 7, 2, 1, 1'b1, 1'b0));
    // Largest negative X with a large positive Y.
    dir_rows.push_back(stim_row(RowByte, 8'h19, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h00, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h80, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // Wheel packets: a drop with every bit but the marker set, then wheel +7 and -8.
    dir_rows.push_back(stim_row(RowMode, 8'h01, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'hF7, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h0C, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h01, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h01, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'hF7, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h08, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h00, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h00, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h08, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // Leave wheel mode with three bytes held: the next byte closes the packet.
    dir_rows.push_back(stim_row(RowByte, 8'h2A, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h05, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h06, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowMode, 8'h00, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h00, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // Enter wheel mode with two bytes held: the packet grows to four bytes.
    dir_rows.push_back(stim_row(RowByte, 8'h08, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h02, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowMode, 8'h01, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h03, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    dir_rows.push_back(stim_row(RowByte, 8'h01, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowMode) write_mode(dir_rows[i].value[0]);
      else send_byte(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 21;
          sink_idle_pct = 50;
        end
        1: begin
          src_idle_pct = 50;
          sink_idle_pct = 21;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < SegsPerPhase; seg++) begin
        // Mode is written at each segment start and flips within a phase, which can fall in the middle of a packet.
        write_mode((seg + phase) % 2 == 0);
        sent_at_start = bytes_sent;
        while (bytes_sent - sent_at_start < SegItems) begin
          pick = $urandom_range(99);
          plen = wheel_q ? 4 : 3;
          b = ByteW'($urandom_range(255));
          if (pick < 10) begin
            // Noise byte, in or out of step.
            send_byte(b, 1'b0, '0);
          end else begin
            b[MarkerBit] = 1'b1;
            send_byte(b, 1'b0, '0);
            // Mostly whole packets, sometimes cut short.
            extra = (pick < 90) ? plen - 1 : $urandom_range(plen - 2, 1);
            repeat (extra) send_byte(ByteW'($urandom_range(255)), 1'b0, '0);
          end
        end
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d bytes in three handshake phases with %0d wheel mode writes.",
             bytes_sent, mode_writes);
    $display("Checked %0d result items: %0d completed packets, %0d dropped bytes.",
             results_seen, packets_checked, drops_checked);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
